FILE: rtl/core/edl_pkg.sv
// Shared constants, types and CORDIC helpers for the environment map lookup.
package edl_pkg;

    localparam int CORD_W     = 40;
    localparam int ANG_W      = 27;
    localparam int CORD_STEPS = 18;
    localparam int SQRT_STEPS = 24;
    localparam int SQ_W       = 48;

    localparam logic signed [ANG_W-1:0] HALF_TURN = 27'sd8388608;
    localparam logic [16:0]             FRAC_ONE  = 17'h10000;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [CORD_W-1:0] a;
        logic signed [CORD_W-1:0] b;
        logic signed [ANG_W-1:0]  ang;
    } t_cord;

    function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 27'sd2097152;
            1:       v = 27'sd1238021;
            2:       v = 27'sd654136;
            3:       v = 27'sd332050;
            4:       v = 27'sd166669;
            5:       v = 27'sd83416;
            6:       v = 27'sd41718;
            7:       v = 27'sd20860;
            8:       v = 27'sd10430;
            9:       v = 27'sd5215;
            10:      v = 27'sd2608;
            11:      v = 27'sd1304;
            12:      v = 27'sd652;
            13:      v = 27'sd326;
            14:      v = 27'sd163;
            15:      v = 27'sd81;
            16:      v = 27'sd41;
            17:      v = 27'sd20;
            default: v = '0;
        endcase
        return v;
    endfunction

    // shift right, rounding toward zero
    function automatic logic signed [CORD_W-1:0] shr_tz(
        input logic signed [CORD_W-1:0] v,
        input int                       s
    );
        logic signed [CORD_W-1:0] bias;
        bias = v[CORD_W-1] ? ((CORD_W'(1) <<< s) - CORD_W'(1)) : '0;
        return (v + bias) >>> s;
    endfunction

    // fold a left-half vector into the right half
    function automatic t_cord cord_init(
        input logic signed [CORD_W-1:0] xv,
        input logic signed [CORD_W-1:0] yv
    );
        t_cord c;
        if (xv[CORD_W-1]) begin
            c.a   = -xv;
            c.b   = -yv;
            c.ang = HALF_TURN;
        end else begin
            c.a   = xv;
            c.b   = yv;
            c.ang = '0;
        end
        return c;
    endfunction

    function automatic t_cord cord_step(input t_cord c, input int i);
        t_cord                    r;
        logic signed [CORD_W-1:0] da;
        logic signed [CORD_W-1:0] db;
        da = shr_tz(c.b, i);
        db = shr_tz(c.a, i);
        if (!c.b[CORD_W-1] && (c.b != '0)) begin
            r.a   = c.a + da;
            r.b   = c.b - db;
            r.ang = c.ang + atan_tab(i);
        end else begin
            r.a   = c.a - da;
            r.b   = c.b + db;
            r.ang = c.ang - atan_tab(i);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/envmap_direction_lookup_core.sv
// Equirectangular environment map store with pipelined bilinear direction lookup.
// One transfer per cycle in while the output side does not stall, one result per sample
// out. The pipeline holds the 24-stage square root and the two 18-stage CORDIC chains
// (azimuth runs beside the root, polar angle after it). Texels live in four identical
// copies of the store, each written on every texel write and each read once per sample
// for one of the four neighbours; texel writes take effect at the same stage as sample
// reads, so items keep their order. A stalled output freezes the whole pipeline.
module envmap_direction_lookup_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [16:0]        i_texel_index,
    input  logic [31:0]        i_texel_red,
    input  logic [31:0]        i_texel_green,
    input  logic [31:0]        i_texel_blue,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_radiance_red,
    output logic [31:0]        o_radiance_green,
    output logic [31:0]        o_radiance_blue
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);

    localparam int S_PH   = 1;
    localparam int S_SQ   = 1;
    localparam int S_TPRE = S_SQ + edl_pkg::SQRT_STEPS;
    localparam int S_TH   = S_TPRE + 1;
    localparam int S_PIX  = S_TH + edl_pkg::CORD_STEPS;
    localparam int S_CRD  = S_PIX + 1;
    localparam int S_ADR  = S_CRD + 1;
    localparam int S_MEM  = S_ADR + 1;
    localparam int S_HBL  = S_MEM + 1;
    localparam int S_VBL  = S_HBL + 1;
    localparam int S_RND  = S_VBL + 1;
    localparam int N_ST   = S_RND + 1;

    typedef struct packed {
        logic                      valid;
        logic                      func;
        logic                      wok;
        logic [AW-1:0]             widx;
        logic [95:0]               wdata;
        logic signed [15:0]        y;
        edl_pkg::t_cord            pc;
        logic                      pzero;
        logic [edl_pkg::SQ_W-1:0]  rem;
        logic [edl_pkg::SQ_W-1:0]  res;
        edl_pkg::t_cord            tc;
        logic                      tzero;
        logic [WW-1:0]             col_raw;
        logic [HW:0]               row_raw;
        logic [15:0]               fx;
        logic [15:0]               fy;
        logic [CW-1:0]             col0;
        logic [CW-1:0]             col1;
        logic [RW-1:0]             row0;
        logic [RW-1:0]             row1;
        logic [3:0][AW-1:0]        adr;
        logic [2:0][47:0]          top;
        logic [2:0][47:0]          bot;
        logic [2:0][63:0]          sum;
        logic [2:0][31:0]          rad;
    } t_stage;

    logic [9:0]    r_map_width;
    logic [8:0]    r_map_height;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          w_adv;
    logic          w_we;
    t_stage        r_st [N_ST];
    t_stage        n_st [N_ST];
    logic [95:0]   r_tex [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 10'd512;
            r_map_height <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                edl_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                edl_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data[8:0];
            endcase
        end
    end

    always_comb begin
        if (r_map_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_map_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_map_width);
        end
        if (r_map_height == '0) begin
            h_eff = HW'(1);
        end else if (int'(r_map_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_map_height);
        end
    end

    assign w_adv      = !(r_st[N_ST-1].valid && (r_st[N_ST-1].func == edl_pkg::FUNC_SAMPLE)
                          && !i_out_ready);
    assign o_in_ready = w_adv;
    assign w_we       = w_adv && r_st[S_ADR].valid && r_st[S_ADR].wok
                        && (r_st[S_ADR].func == edl_pkg::FUNC_WRITE);

    // entry stage: squares, azimuth vector, write payload
    always_comb begin
        logic signed [31:0]                xx;
        logic signed [31:0]                zz;
        logic [31:0]                       sq;
        logic signed [edl_pkg::CORD_W-1:0] xv;
        logic signed [edl_pkg::CORD_W-1:0] yv;
        n_st[0]       = '0;
        xx            = i_dir_x * i_dir_x;
        zz            = i_dir_z * i_dir_z;
        sq            = $unsigned(xx) + $unsigned(zz);
        xv            = edl_pkg::CORD_W'(i_dir_x) <<< 16;
        yv            = -(edl_pkg::CORD_W'(i_dir_z) <<< 16);
        n_st[0].valid = i_in_valid;
        n_st[0].func  = i_func;
        n_st[0].wok   = (32'(i_texel_index) < 32'(DEPTH));
        n_st[0].widx  = AW'(i_texel_index);
        n_st[0].wdata = {i_texel_blue, i_texel_green, i_texel_red};
        n_st[0].y     = i_dir_y;
        n_st[0].pc    = edl_pkg::cord_init(xv, yv);
        n_st[0].pzero = (i_dir_x == '0) && (i_dir_z == '0);
        n_st[0].rem   = {sq, 16'h0000};
        n_st[0].res   = '0;
    end

    for (genvar k = 1; k < N_ST; k++) begin : g_stage
        localparam int PH_I = (k >= S_PH && k < S_PH + edl_pkg::CORD_STEPS) ? k - S_PH : 0;
        localparam int SQ_I = (k >= S_SQ && k < S_SQ + edl_pkg::SQRT_STEPS) ? k - S_SQ : 0;
        localparam int TH_I = (k >= S_TH && k < S_TH + edl_pkg::CORD_STEPS) ? k - S_TH : 0;

        always_comb begin
            logic [edl_pkg::SQ_W-1:0]          bit_v;
            logic [edl_pkg::SQ_W-1:0]          trial;
            logic signed [edl_pkg::CORD_W-1:0] xv;
            logic signed [edl_pkg::CORD_W-1:0] yv;
            logic signed [edl_pkg::ANG_W-1:0]  pang;
            logic signed [edl_pkg::ANG_W-1:0]  tang;
            logic [edl_pkg::ANG_W-1:0]         psum;
            logic [23:0]                       phi_t;
            logic [23:0]                       th_t;
            logic [24+WW-1:0]                  pxf;
            logic [24+HW-1:0]                  pyf;
            logic [WW-1:0]                     c0;
            logic [WW:0]                       c1;
            logic [HW:0]                       hx;
            logic [HW:0]                       r0;
            logic [HW:0]                       r1;
            logic [RW+WW-1:0]                  m0;
            logic [RW+WW-1:0]                  m1;
            logic [16:0]                       wx0;
            logic [16:0]                       wy0;
            logic [31:0]                       t00;
            logic [31:0]                       t01;
            logic [31:0]                       t10;
            logic [31:0]                       t11;
            logic [32:0]                       rr;
            n_st[k] = r_st[k-1];
            bit_v   = edl_pkg::SQ_W'(1) << (46 - 2 * SQ_I);
            trial   = r_st[k-1].res + bit_v;
            hx      = {1'b0, h_eff};

            if (k >= S_PH && k < S_PH + edl_pkg::CORD_STEPS) begin
                n_st[k].pc = edl_pkg::cord_step(r_st[k-1].pc, PH_I);
            end
            if (k >= S_SQ && k < S_SQ + edl_pkg::SQRT_STEPS) begin
                if (r_st[k-1].rem >= trial) begin
                    n_st[k].rem = r_st[k-1].rem - trial;
                    n_st[k].res = (r_st[k-1].res >> 1) + bit_v;
                end else begin
                    n_st[k].res = r_st[k-1].res >> 1;
                end
            end
            if (k == S_TPRE) begin
                yv = signed'(edl_pkg::CORD_W'({r_st[k-1].res[23:0], 8'h00}));
                xv = edl_pkg::CORD_W'(r_st[k-1].y) <<< 16;
                n_st[k].tc    = edl_pkg::cord_init(xv, yv);
                n_st[k].tzero = (r_st[k-1].res == '0) && (r_st[k-1].y == '0);
            end
            if (k >= S_TH && k < S_TH + edl_pkg::CORD_STEPS) begin
                n_st[k].tc = edl_pkg::cord_step(r_st[k-1].tc, TH_I);
            end
            if (k == S_PIX) begin
                pang  = r_st[k-1].pzero ? '0 : r_st[k-1].pc.ang;
                psum  = pang + edl_pkg::HALF_TURN;
                phi_t = psum[23:0];
                tang  = r_st[k-1].tzero ? '0 : r_st[k-1].tc.ang;
                if (tang[edl_pkg::ANG_W-1]) begin
                    tang = '0;
                end else if (tang > edl_pkg::HALF_TURN) begin
                    tang = edl_pkg::HALF_TURN;
                end
                th_t            = tang[23:0];
                pxf             = (24+WW)'(phi_t) * (24+WW)'(w_eff);
                pyf             = (24+HW)'(th_t) * (24+HW)'(h_eff);
                n_st[k].col_raw = pxf[24 +: WW];
                n_st[k].fx      = pxf[23:8];
                n_st[k].row_raw = pyf[23 +: HW+1];
                n_st[k].fy      = pyf[22:7];
            end
            if (k == S_CRD) begin
                c0 = (r_st[k-1].col_raw >= w_eff) ? '0 : r_st[k-1].col_raw;
                c1 = {1'b0, c0} + (WW+1)'(1);
                r0 = (r_st[k-1].row_raw >= hx) ? hx - (HW+1)'(1) : r_st[k-1].row_raw;
                r1 = r0 + (HW+1)'(1);
                n_st[k].col0 = CW'(c0);
                n_st[k].col1 = (c1 >= {1'b0, w_eff}) ? '0 : CW'(c1);
                n_st[k].row0 = RW'(r0);
                n_st[k].row1 = (r1 >= hx) ? RW'(hx - (HW+1)'(1)) : RW'(r1);
            end
            if (k == S_ADR) begin
                m0 = (RW+WW)'(r_st[k-1].row0) * (RW+WW)'(w_eff);
                m1 = (RW+WW)'(r_st[k-1].row1) * (RW+WW)'(w_eff);
                n_st[k].adr[0] = AW'(m0 + (RW+WW)'(r_st[k-1].col0));
                n_st[k].adr[1] = AW'(m0 + (RW+WW)'(r_st[k-1].col1));
                n_st[k].adr[2] = AW'(m1 + (RW+WW)'(r_st[k-1].col0));
                n_st[k].adr[3] = AW'(m1 + (RW+WW)'(r_st[k-1].col1));
            end
            if (k == S_HBL) begin
                wx0 = edl_pkg::FRAC_ONE - {1'b0, r_st[k-1].fx};
                for (int c = 0; c < 3; c++) begin
                    t00 = r_tex[0][32*c +: 32];
                    t01 = r_tex[1][32*c +: 32];
                    t10 = r_tex[2][32*c +: 32];
                    t11 = r_tex[3][32*c +: 32];
                    n_st[k].top[c] = 48'(t00) * 48'(wx0) + 48'(t01) * 48'(r_st[k-1].fx);
                    n_st[k].bot[c] = 48'(t10) * 48'(wx0) + 48'(t11) * 48'(r_st[k-1].fx);
                end
            end
            if (k == S_VBL) begin
                wy0 = edl_pkg::FRAC_ONE - {1'b0, r_st[k-1].fy};
                for (int c = 0; c < 3; c++) begin
                    n_st[k].sum[c] = 64'(r_st[k-1].top[c]) * 64'(wy0)
                                   + 64'(r_st[k-1].bot[c]) * 64'(r_st[k-1].fy);
                end
            end
            if (k == S_RND) begin
                for (int c = 0; c < 3; c++) begin
                    rr = 33'(r_st[k-1].sum[c][63:32]) + 33'(r_st[k-1].sum[c][31]);
                    n_st[k].rad[c] = rr[32] ? '1 : rr[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_ST; k++) begin
                r_st[k].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    for (genvar m = 0; m < 4; m++) begin : g_bank
        logic [95:0] r_mem [0:DEPTH-1];

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[r_st[S_ADR].widx] <= r_st[S_ADR].wdata;
            end
            if (w_adv) begin
                r_tex[m] <= r_mem[r_st[S_ADR].adr[m]];
            end
        end
    end

    assign o_out_valid      = r_st[N_ST-1].valid && (r_st[N_ST-1].func == edl_pkg::FUNC_SAMPLE);
    assign o_radiance_red   = r_st[N_ST-1].rad[0];
    assign o_radiance_green = r_st[N_ST-1].rad[1];
    assign o_radiance_blue  = r_st[N_ST-1].rad[2];

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_st[0]))
        else $error("entry stage moved during a stall");

    a_addr_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st[S_ADR].valid && (r_st[S_ADR].func == edl_pkg::FUNC_SAMPLE))
        |-> ((32'(r_st[S_ADR].adr[0]) < 32'(DEPTH)) && (32'(r_st[S_ADR].adr[3]) < 32'(DEPTH))))
        else $error("sample address beyond the store");

    a_coord_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st[S_CRD].valid && (r_st[S_CRD].func == edl_pkg::FUNC_SAMPLE))
        |-> ((WW'(r_st[S_CRD].col1) < w_eff) && (HW'(r_st[S_CRD].row1) < h_eff)))
        else $error("neighbour coordinate outside the map");
`endif

endmodule
